@@ hw/rtl/kvcrc_pkg.sv @@
// Shared types, constants and helper functions for the environment block checker.
`timescale 1ns / 1ps

package kvcrc_pkg;

    localparam int unsigned POS_W = 22;
    localparam int unsigned CNT_W = 20;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [POS_W-1:0] CAND_MIN = 22'h001000;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef logic [1:0] t_verdict;
    localparam t_verdict VERDICT_REJECT     = 2'd0;
    localparam t_verdict VERDICT_STRUCTURAL = 2'd1;
    localparam t_verdict VERDICT_VERIFIED   = 2'd2;

    // One classified word passed from the front end to the back end.
    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic             hdr_en;     // byte belongs to the stored CRC
        logic [1:0]       hdr_lane;   // byte lane inside the stored CRC
        logic             body;       // byte is covered by CRC and grammar
        logic             over;       // body index beyond the window
        logic             cand;       // total length is a candidate size
        logic [POS_W-1:0] total;      // byte count including this byte
        logic [POS_W-1:0] body_idx;   // index of this byte in the body
        logic             is_zero;
        logic             is_eq;
        logic             is_key;
        logic             is_value;
    } t_cls_word;

    function automatic logic is_key_byte(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
    endfunction

    function automatic logic is_value_byte(input logic [7:0] c);
        return (c >= 8'h20 && c <= 8'h7E) || (c == 8'h09) ||
               (c == 8'h0A) || (c == 8'h0D);
    endfunction

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/kvcrc_queue.sv @@
// Two-entry queue of classified words between the front and back ends.
`timescale 1ns / 1ps

module kvcrc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  kvcrc_pkg::t_cls_word i_word,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output kvcrc_pkg::t_cls_word o_word
);
    import kvcrc_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_cls_word          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + CNT_QW'(1);
            else if (do_pop && !do_push) r_count <= r_count - CNT_QW'(1);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_QW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ hw/rtl/kvcrc_front.sv @@
// Front end: tracks byte position and classifies each accepted byte.
`timescale 1ns / 1ps

module kvcrc_front #(
    parameter int unsigned MAX_ENV_BYTES = 2097152
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  logic                 i_redundant,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output kvcrc_pkg::t_cls_word o_word
);
    import kvcrc_pkg::*;

    localparam logic [POS_W-1:0] MAX_W = POS_W'(MAX_ENV_BYTES);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] hl, total;
    logic             accept;

    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;
    assign hl       = i_redundant ? POS_W'(5) : POS_W'(4);
    assign total    = r_pos + POS_W'(1);

    always_comb begin
        o_word          = '0;
        o_word.data     = i_data_byte;
        o_word.last     = i_last_byte;
        o_word.hdr_en   = (r_pos < POS_W'(4));
        o_word.hdr_lane = r_pos[1:0];
        o_word.body     = (r_pos >= hl) && (r_pos != POS_MAX);
        o_word.body_idx = r_pos - hl;
        o_word.over     = (o_word.body_idx >= MAX_W);
        o_word.total    = total;
        // power-of-two size inside the candidate window
        o_word.cand     = (total >= CAND_MIN) && (total <= MAX_W) &&
                          ((total & (total - POS_W'(1))) == '0);
        o_word.is_zero  = (i_data_byte == 8'h00);
        o_word.is_eq    = (i_data_byte == 8'h3D);
        o_word.is_key   = is_key_byte(i_data_byte);
        o_word.is_value = is_value_byte(i_data_byte);
    end

    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_last_byte)           n_pos = '0;
            else if (r_pos != POS_MAX) n_pos = total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

@@ hw/rtl/kvcrc_back.sv @@
// Back end: CRC, entry grammar, size matching and the result register.
`timescale 1ns / 1ps

module kvcrc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  kvcrc_pkg::t_cls_word i_word,
    output logic                 o_q_pop,
    input  logic                 i_redundant,
    input  logic [7:0]           i_min_entries,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [1:0]           o_verdict,
    output logic [19:0]          o_entry_count,
    output logic [21:0]          o_env_size,
    output logic                 o_redundant
);
    import kvcrc_pkg::*;

    localparam logic [1:0] GS_START = 2'd0;
    localparam logic [1:0] GS_KEY   = 2'd1;
    localparam logic [1:0] GS_VALUE = 2'd2;

    logic [31:0]      r_stored, n_stored;
    logic [31:0]      r_crc, n_crc;
    logic [1:0]       r_gs, n_gs;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_term, n_term;
    logic             r_fail, n_fail;
    logic [POS_W-1:0] r_used, n_used;
    logic [POS_W-1:0] r_matched, n_matched;
    logic             r_exact, n_exact;

    logic             r_out_valid;
    t_verdict         r_verdict, n_verdict;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic [POS_W-1:0] r_out_size, n_out_size;
    logic             r_out_red, n_out_red;

    logic [31:0]      crc_upd;
    logic             crc_ok, accept_ok, load_out, out_free;
    logic [POS_W-1:0] hl;

    assign hl       = i_redundant ? POS_W'(5) : POS_W'(4);
    assign out_free = !r_out_valid || i_pop;
    // a closing word needs room in the result register; others never wait
    assign o_q_pop  = i_q_valid && (!i_word.last || out_free);
    assign load_out = o_q_pop && i_word.last;

    assign crc_upd  = crc_byte(r_crc, i_word.data);
    assign crc_ok   = (~crc_upd == r_stored);

    always_comb begin
        n_stored  = r_stored;
        n_crc     = r_crc;
        n_gs      = r_gs;
        n_cnt     = r_cnt;
        n_term    = r_term;
        n_fail    = r_fail;
        n_used    = r_used;
        n_matched = r_matched;
        n_exact   = r_exact;

        if (i_word.hdr_en) begin
            n_stored[8*i_word.hdr_lane +: 8] = i_word.data;
        end

        if (i_word.body) begin
            n_crc = crc_upd;
            if (!r_term && !r_fail) begin
                if (i_word.over) begin
                    n_fail = 1'b1;
                end else begin
                    unique case (r_gs)
                        GS_START: begin
                            if (i_word.is_zero) begin
                                n_term = 1'b1;
                                n_used = i_word.body_idx + POS_W'(1);
                            end else if (i_word.is_key) begin
                                n_gs = GS_KEY;
                            end else begin
                                n_fail = 1'b1;
                            end
                        end
                        GS_KEY: begin
                            if (i_word.is_eq)       n_gs = GS_VALUE;
                            else if (!i_word.is_key) n_fail = 1'b1;
                        end
                        default: begin
                            if (i_word.is_zero) begin
                                if (r_cnt != CNT_MAX) n_cnt = r_cnt + CNT_W'(1);
                                n_gs = GS_START;
                            end else if (!i_word.is_value) begin
                                n_fail = 1'b1;
                            end
                        end
                    endcase
                end
            end
            if (!r_term && n_term && crc_ok) n_exact = 1'b1;
            if ((r_matched == '0) && i_word.cand && crc_ok) n_matched = i_word.total;
        end
    end

    // verdict from the state as it stands after the closing byte
    always_comb begin
        accept_ok  = n_term && !n_fail && (n_cnt >= CNT_W'(i_min_entries));
        n_verdict  = VERDICT_REJECT;
        n_out_cnt  = '0;
        n_out_size = '0;
        n_out_red  = 1'b0;
        if (accept_ok) begin
            n_out_cnt = n_cnt;
            if (n_matched != '0) begin
                n_verdict  = VERDICT_VERIFIED;
                n_out_size = n_matched;
                n_out_red  = i_redundant;
            end else if (n_exact) begin
                n_verdict  = VERDICT_VERIFIED;
                n_out_size = n_used + hl;
                n_out_red  = i_redundant;
            end else begin
                n_verdict  = VERDICT_STRUCTURAL;
                n_out_size = n_used + POS_W'(4);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load_out) begin
            r_stored  <= '0;
            r_crc     <= CRC_INIT;
            r_gs      <= GS_START;
            r_cnt     <= '0;
            r_term    <= 1'b0;
            r_fail    <= 1'b0;
            r_used    <= '0;
            r_matched <= '0;
            r_exact   <= 1'b0;
        end else if (o_q_pop) begin
            r_stored  <= n_stored;
            r_crc     <= n_crc;
            r_gs      <= n_gs;
            r_cnt     <= n_cnt;
            r_term    <= n_term;
            r_fail    <= n_fail;
            r_used    <= n_used;
            r_matched <= n_matched;
            r_exact   <= n_exact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_verdict  <= n_verdict;
            r_out_cnt  <= n_out_cnt;
            r_out_size <= n_out_size;
            r_out_red  <= n_out_red;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_verdict     = r_verdict;
    assign o_entry_count = r_out_cnt;
    assign o_env_size    = r_out_size;
    assign o_redundant   = r_out_red;

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_verdict == VERDICT_REJECT)
        |-> (r_out_cnt == '0) && (r_out_size == '0) && !r_out_red)
        else $error("rejected result carries nonzero fields");

    a_struct_not_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_verdict == VERDICT_STRUCTURAL) |-> !r_out_red)
        else $error("structural result flagged redundant");

    a_run_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_gs == GS_START) && (r_cnt == '0) && !r_term && !r_fail
                     && (r_crc == CRC_INIT) && (r_matched == '0))
        else $error("run state not cleared after closing word");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result loaded over a waiting result");

endmodule

@@ hw/rtl/kv_env_block_crc_validator.sv @@
// Top level of the key=value environment block CRC checker.
`timescale 1ns / 1ps

// Usage
//   Input side is a queue: drive i_data_byte/i_last_byte and raise push; a
//   word is taken at a clock edge with push high and full low. Feed the
//   image one byte per word starting at the candidate header; mark the final
//   byte with i_last_byte.
//   Result side is a queue too: while empty is low the verdict, entry count,
//   size and redundant flag are valid; pop takes the word. Exactly one
//   result is produced per run, on the byte marked last.
//   Config: i_cfg_we writes i_cfg_data to register i_cfg_index (0 header
//   length, 1 minimum entry count). Write only while the block is idle.
// Throughput and output
//   One byte per cycle unless a closing byte waits for the result register;
//   the byte-wide CRC and the grammar FSM in the back end each take a whole
//   byte per update. A result is registered as its closing byte leaves the queue.
// Reset and stalls
//   Synchronous active-low reset clears the run state, both queues and sets
//   the header length to 4 and the minimum entry count to 4.
//   While a result waits, input bytes keep flowing through the back end; only
//   the next closing byte waits, and the two-word front queue then fills and
//   raises full.

module kv_env_block_crc_validator #(
    parameter int unsigned MAX_ENV_BYTES = 2097152
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input queue
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result queue
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_verdict,
    output logic [19:0] o_entry_count,
    output logic [21:0] o_env_size,
    output logic        o_redundant,
    // config write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import kvcrc_pkg::*;

    localparam logic CFG_HEADER_LENGTH = 1'b0;
    localparam logic CFG_MIN_ENTRIES   = 1'b1;

    logic [2:0] r_header_length;
    logic [7:0] r_min_entries;
    logic       redundant;

    t_cls_word  f_word, q_word;
    logic       f_push, q_full, q_valid, q_pop;

    // any header length other than 5 behaves as the single layout
    assign redundant = (r_header_length == 3'd5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_length <= 3'd4;
            r_min_entries   <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER_LENGTH: r_header_length <= i_cfg_data[2:0];
                CFG_MIN_ENTRIES:   r_min_entries   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full = q_full;

    kvcrc_front #(
        .MAX_ENV_BYTES (MAX_ENV_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_redundant (redundant),
        .i_q_full    (q_full),
        .o_q_push    (f_push),
        .o_word      (f_word)
    );

    kvcrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_word  (f_word),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_word  (q_word)
    );

    kvcrc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_word        (q_word),
        .o_q_pop       (q_pop),
        .i_redundant   (redundant),
        .i_min_entries (r_min_entries),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_verdict     (o_verdict),
        .o_entry_count (o_entry_count),
        .o_env_size    (o_env_size),
        .o_redundant   (o_redundant)
    );

endmodule

@@ dv/kv_env_block_crc_validator_test.sv @@
// Self-checking testbench for the key=value environment block CRC checker.
`timescale 1ns / 1ps

module kv_env_block_crc_validator_test;
    import kvcrc_pkg::*;

    localparam int unsigned ENV_WINDOW    = 2097152;
    // Slowest legal run is roughly 1.4k words with the longest gaps; keep a wide margin.
    localparam int          CYCLE_LIMIT   = 2000000;
    localparam int          SETTLE_CYCLES = 6;      // idle clocks after the last result drains
    localparam int          PHASE_BYTES   = 150;    // minimum random words per config phase
    localparam int          MAX_REPORTS   = 10;

    localparam logic [7:0]  CH_NUL = 8'h00;
    localparam logic [7:0]  CH_EQ  = 8'h3D;
    localparam logic [7:0]  CH_TAB = 8'h09;
    localparam logic [7:0]  CH_LF  = 8'h0A;
    localparam logic [7:0]  CH_CR  = 8'h0D;

    typedef enum logic {
        REG_HDR_LEN     = 1'b0,
        REG_MIN_ENTRIES = 1'b1
    } cfg_reg_e;

    // Entry grammar position.
    typedef enum logic [1:0] {
        KV_ENTRY_START,
        KV_IN_KEY,
        KV_IN_VALUE
    } kv_phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } image_word_t;

    typedef struct packed {
        t_verdict    verdict;
        logic [19:0] entries;
        logic [21:0] size;
        logic        redundant;
    } env_verdict_t;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [1:0]  o_verdict;
    logic [19:0] o_entry_count;
    logic [21:0] o_env_size;
    logic        o_redundant;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data  = 8'h00;

    kv_env_block_crc_validator #(
        .MAX_ENV_BYTES (ENV_WINDOW)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .empty         (empty),
        .pop           (pop),
        .o_verdict     (o_verdict),
        .o_entry_count (o_entry_count),
        .o_env_size    (o_env_size),
        .o_redundant   (o_redundant),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: registers plus the per-image scan state
    // ------------------------------------------------------------------
    logic [2:0]   cfg_hdr_len;
    logic [7:0]   cfg_min_entries;
    logic [21:0]  img_pos;
    logic [31:0]  hdr_crc;        // stored CRC collected from the header
    logic [31:0]  body_crc;       // running CRC, not yet inverted
    kv_phase_e    kv_phase;
    logic [19:0]  kv_entries;
    logic         list_done;
    logic         list_bad;
    logic         exact_hit;
    logic [21:0]  used_len;
    logic [21:0]  hit_size;       // zero while no candidate size matched

    env_verdict_t awaited_verdicts[$];
    image_word_t  image_bytes[$];

    int           errors      = 0;
    int           cycle_count = 0;
    int           send_pause  = 0;
    int           send_steady = 0;
    int           drain_pause = 0;

    // Stimulus scratch: body of the image under construction.
    logic [7:0]   body_buf[$];
    int           term_at;        // index of the list terminator, -1 if none
    int           stim_hl;
    int           shipped_bytes;

    // Bit-serial reflected CRC-32, LSB of the byte first.
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[31:1]} ^ (fb ? 32'hEDB88320 : 32'h0);
        end
        return r;
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        logic [7:0] up;
        up = c & 8'hDF;   // fold lower case onto upper case
        return (up >= 8'h41 && up <= 8'h5A) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
    endfunction

    function automatic logic value_char(input logic [7:0] c);
        return (c >= 8'h20 && c < 8'h80 && c != 8'h7F) ||
               c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    task automatic restart_scan();
        img_pos    = '0;
        hdr_crc    = '0;
        body_crc   = 32'hFFFFFFFF;
        kv_phase   = KV_ENTRY_START;
        kv_entries = '0;
        list_done  = 1'b0;
        list_bad   = 1'b0;
        exact_hit  = 1'b0;
        used_len   = '0;
        hit_size   = '0;
    endtask

    // Grammar step for one body byte; stops for good on terminator or error.
    task automatic scan_body_byte(input logic [7:0] c, input logic [21:0] idx);
        if (list_done || list_bad)
            return;
        if (idx >= ENV_WINDOW) begin
            list_bad = 1'b1;
            return;
        end
        case (kv_phase)
            KV_ENTRY_START: begin
                if (c == CH_NUL) begin
                    list_done = 1'b1;
                    used_len  = idx + 22'd1;
                end else if (is_name_char(c)) begin
                    kv_phase = KV_IN_KEY;
                end else begin
                    list_bad = 1'b1;
                end
            end
            KV_IN_KEY: begin
                if (c == CH_EQ)
                    kv_phase = KV_IN_VALUE;
                else if (!is_name_char(c))
                    list_bad = 1'b1;
            end
            default: begin
                if (c == CH_NUL) begin
                    if (kv_entries != CNT_MAX)
                        kv_entries = kv_entries + 20'd1;
                    kv_phase = KV_ENTRY_START;
                end else if (!value_char(c)) begin
                    list_bad = 1'b1;
                end
            end
        endcase
    endtask

    // One accepted image word; the closing word queues its verdict.
    task automatic absorb_image_byte(input logic [7:0] c, input logic last);
        logic [21:0]  hl;
        logic [21:0]  total;
        logic         crc_ok;
        logic         was_done;
        env_verdict_t want;
        hl = (cfg_hdr_len == 3'd5) ? 22'd5 : 22'd4;
        if (img_pos < hl) begin
            if (img_pos < 22'd4)
                hdr_crc[8*img_pos[1:0] +: 8] = c;
        end else if (img_pos != POS_MAX) begin
            was_done = list_done;
            total    = img_pos + 22'd1;
            body_crc = crc32_step(body_crc, c);
            crc_ok   = ((body_crc ^ 32'hFFFFFFFF) == hdr_crc);
            scan_body_byte(c, img_pos - hl);
            if (!was_done && list_done && crc_ok)
                exact_hit = 1'b1;
            // power-of-two candidate sizes, first hit sticks
            if (hit_size == '0 && total >= CAND_MIN && total <= ENV_WINDOW &&
                (total & (total - 22'd1)) == '0 && crc_ok)
                hit_size = total;
        end
        if (img_pos != POS_MAX)
            img_pos = img_pos + 22'd1;
        if (last) begin
            want = '0;
            if (list_done && !list_bad && kv_entries >= cfg_min_entries) begin
                want.entries = kv_entries;
                if (hit_size != '0) begin
                    want.verdict   = VERDICT_VERIFIED;
                    want.size      = hit_size;
                    want.redundant = (hl == 22'd5);
                end else if (exact_hit) begin
                    want.verdict   = VERDICT_VERIFIED;
                    want.size      = used_len + hl;
                    want.redundant = (hl == 22'd5);
                end else begin
                    want.verdict = VERDICT_STRUCTURAL;
                    want.size    = used_len + 22'd4;
                end
            end
            awaited_verdicts.insert(awaited_verdicts.size(), want);
            restart_scan();
        end
    endtask

    // Mostly short gaps, some medium, a few long ones.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds queued image words, tracks config writes and accepted
    // words for the predictor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        image_word_t w;
        if (!i_rst_n) begin
            push            <= 1'b0;
            cfg_hdr_len     = 3'd4;
            cfg_min_entries = 8'd4;
            restart_scan();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_HDR_LEN)
                    cfg_hdr_len = i_cfg_data[2:0];
                else
                    cfg_min_entries = i_cfg_data;
            end
            if (push && !full)
                absorb_image_byte(i_data_byte, i_last_byte);

            if (push && full) begin
                // word still waiting; hold everything
            end else if (send_pause > 0) begin
                push       <= 1'b0;
                send_pause = send_pause - 1;
            end else if (image_bytes.size() > 0) begin
                w = image_bytes.pop_front();
                push        <= 1'b1;
                i_data_byte <= w.data;
                i_last_byte <= w.last;
                // occasional gap-free stretches between the random gaps
                if (send_steady > 0)
                    send_steady = send_steady - 1;
                else if ($urandom_range(0, 39) == 0)
                    send_steady = $urandom_range(20, 80);
                send_pause = (send_steady > 0) ? 0 : pick_pause();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random pop stalls, checks each result word in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        env_verdict_t got;
        env_verdict_t want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.verdict   = o_verdict;
                got.entries   = o_entry_count;
                got.size      = o_env_size;
                got.redundant = o_redundant;
                if (awaited_verdicts.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result word v=%0d n=%0d sz=%0d r=%0d",
                                 $time, got.verdict, got.entries, got.size, got.redundant);
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (got.verdict !== want.verdict || got.entries !== want.entries ||
                        got.size !== want.size || got.redundant !== want.redundant) begin
                        errors = errors + 1;
                        if (errors <= MAX_REPORTS) begin
                            $write("%0t: mismatch exp v=%0d n=%0d sz=%0d r=%0d,",
                                   $time, want.verdict, want.entries, want.size,
                                   want.redundant);
                            $display(" got v=%0d n=%0d sz=%0d r=%0d",
                                     got.verdict, got.entries, got.size, got.redundant);
                        end
                    end
                end
                drain_pause = pick_pause();
            end else if (drain_pause == 0 && $urandom_range(0, 15) == 0) begin
                drain_pause = pick_pause();
            end
            if (drain_pause > 0) begin
                pop         <= 1'b0;
                drain_pause = drain_pause - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Hang guard.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("kv_env_block_crc_validator_test: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Image builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_key_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'(8'h41 + r);
        if (r < 52)
            return 8'(8'h61 + r - 26);
        if (r < 62)
            return 8'(8'h30 + r - 52);
        return 8'h5F;
    endfunction

    function automatic logic [7:0] pick_value_char();
        int r;
        r = $urandom_range(0, 97);
        if (r < 95)
            return 8'(8'h20 + r);
        if (r == 95)
            return CH_TAB;
        if (r == 96)
            return CH_LF;
        return CH_CR;
    endfunction

    task automatic append_body(input logic [7:0] b);
        body_buf.insert(body_buf.size(), b);
    endtask

    task automatic start_body();
        body_buf.delete();
        term_at = -1;
    endtask

    task automatic add_entry(input string key, input string val);
        for (int i = 0; i < key.len(); i++)
            append_body(key[i]);
        append_body(CH_EQ);
        for (int i = 0; i < val.len(); i++)
            append_body(val[i]);
        append_body(CH_NUL);
    endtask

    task automatic add_random_entries(input int n, input int max_key, input int max_val);
        repeat (n) begin
            repeat ($urandom_range(1, max_key))
                append_body(pick_key_char());
            append_body(CH_EQ);
            repeat ($urandom_range(0, max_val))
                append_body(pick_value_char());
            append_body(CH_NUL);
        end
    endtask

    task automatic close_list();
        term_at = body_buf.size();
        append_body(CH_NUL);
    endtask

    task automatic add_padding(input int n);
        repeat (n)
            append_body(8'($urandom));
    endtask

    // Prefix the header and queue the image. crc_len < 0 stores a random
    // CRC, otherwise the CRC of that many body bytes. keep > 0 cuts the image.
    task automatic ship_image(input int crc_len, input int keep);
        logic [31:0] crc;
        image_word_t w;
        int          n;
        logic [7:0]  img[$];
        if (crc_len < 0) begin
            crc = $urandom;
        end else begin
            crc = 32'hFFFFFFFF;
            for (int i = 0; i < crc_len; i++)
                crc = crc32_step(crc, body_buf[i]);
            crc = ~crc;
        end
        img.insert(img.size(), crc[7:0]);
        img.insert(img.size(), crc[15:8]);
        img.insert(img.size(), crc[23:16]);
        img.insert(img.size(), crc[31:24]);
        if (stim_hl == 5)
            img.insert(img.size(), 8'($urandom));    // flag byte, not checked
        foreach (body_buf[i])
            img.insert(img.size(), body_buf[i]);
        n = (keep > 0 && keep < img.size()) ? keep : img.size();
        @(negedge i_clk);
        for (int i = 0; i < n; i++) begin
            w.data = img[i];
            w.last = (i == n - 1);
            image_bytes.insert(image_bytes.size(), w);
        end
        shipped_bytes = shipped_bytes + n;
    endtask

    // Random image: mostly well-formed lists, the rest broken or noise.
    task automatic random_image();
        int r;
        int c;
        r = $urandom_range(0, 99);
        c = $urandom_range(0, 9);
        start_body();
        if (r < 60) begin
            add_random_entries($urandom_range(0, 9), 6, 10);
            close_list();
            if ($urandom_range(0, 2) == 0)
                add_padding($urandom_range(1, 12));
            // CRC at the terminator, over the whole body, or junk
            ship_image(c < 6 ? term_at + 1 : (c < 8 ? body_buf.size() : -1), 0);
        end else if (r < 75) begin
            add_random_entries($urandom_range(1, 6), 6, 10);
            close_list();
            if ($urandom_range(0, 3) == 0)
                add_padding($urandom_range(1, 6));
            repeat ($urandom_range(1, 2))
                body_buf[$urandom_range(0, body_buf.size() - 1)] = 8'($urandom);
            ship_image(c < 7 ? term_at + 1 : -1, 0);
        end else if (r < 87) begin
            // list cut off before its terminator
            add_random_entries($urandom_range(1, 6), 6, 10);
            repeat ($urandom_range(0, 5))
                if (body_buf.size() > 1)
                    void'(body_buf.pop_back());
            ship_image(body_buf.size(), 0);
        end else if (r < 94) begin
            ship_image(-1, $urandom_range(1, stim_hl));
        end else begin
            add_padding($urandom_range(1, 30));
            ship_image(c < 5 ? body_buf.size() : -1, 0);
        end
    endtask

    // Special cases at the reset config (4-byte header, 4 entries needed).
    task automatic directed_images();
        // closing word inside the header, and a header with no body
        start_body();
        ship_image(-1, 1);
        start_body();
        ship_image(-1, 0);

        // key and value extremes, CRC matching at the terminator
        start_body();
        add_entry("Az09_", "\t\n\r ~");
        add_entry("Z", "");
        add_entry("a", "x=y");
        add_entry("z_9", "~~");
        close_list();
        ship_image(term_at + 1, 0);

        // same list, stored CRC wrong: structural only
        ship_image(-1, 0);

        // padding after the terminator, CRC still taken at the terminator
        start_body();
        add_random_entries(5, 3, 3);
        close_list();
        append_body(8'hFF);
        append_body(CH_NUL);
        append_body(8'h80);
        ship_image(term_at + 1, 0);

        // too few entries
        start_body();
        add_random_entries(3, 3, 3);
        close_list();
        ship_image(term_at + 1, 0);

        // entry starting with '=', key with no '=', bad key bytes, bad value byte
        start_body();
        add_random_entries(4, 2, 2);
        append_body(CH_EQ);
        close_list();
        ship_image(term_at + 1, 0);

        start_body();
        add_random_entries(4, 2, 2);
        add_entry("AB", "");
        body_buf[body_buf.size() - 2] = CH_NUL;
        close_list();
        ship_image(term_at + 1, 0);

        start_body();
        add_entry("k-1", "v");
        add_random_entries(4, 2, 2);
        close_list();
        ship_image(term_at + 1, 0);

        start_body();
        add_random_entries(4, 2, 2);
        append_body(8'h41);
        append_body(CH_EQ);
        append_body(8'h7F);
        append_body(CH_NUL);
        close_list();
        ship_image(term_at + 1, 0);

        start_body();
        append_body(8'h80);
        append_body(CH_EQ);
        append_body(8'h1F);
        append_body(CH_NUL);
        close_list();
        ship_image(term_at + 1, 0);

        // list never terminated
        start_body();
        add_random_entries(5, 3, 3);
        ship_image(body_buf.size(), 0);
    endtask

    // Wait for every image word and result to drain, then let the pipe empty.
    task automatic settle();
        do
            @(negedge i_clk);
        while (image_bytes.size() != 0 || push || awaited_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [2:0] hl;
        logic [7:0] min_n;
        logic [7:0] d;
        shipped_bytes = 0;
        stim_hl       = 4;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_images();
        settle();

        // Config phases: header lengths 4, 5 and the odd codes that act as
        // 4; entry minimum from 0 up to 255.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       begin hl = 3'd5; min_n = 8'd0;   end
                1:       begin hl = 3'd4; min_n = 8'd255; end
                2:       begin hl = 3'd7; min_n = 8'd1;   end
                3:       begin hl = 3'd5; min_n = 8'd2;   end
                4:       begin hl = 3'd0; min_n = 8'd6;   end
                default: begin hl = 3'd4; min_n = 8'd3;   end
            endcase
            d      = 8'($urandom);
            d[2:0] = hl;                    // upper bits are don't-care
            write_reg(REG_HDR_LEN, d);
            write_reg(REG_MIN_ENTRIES, min_n);
            stim_hl = (hl == 3'd5) ? 5 : 4;

            shipped_bytes = 0;
            while (shipped_bytes < PHASE_BYTES)
                random_image();
            settle();
        end

        if (errors == 0)
            $display("kv_env_block_crc_validator_test: clean");
        else
            $display("kv_env_block_crc_validator_test: errors");
        $finish;
    end

endmodule
